[sv/assert_macros.svh]
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/qr_pkg.sv]
// Shared types and constants of the quadratic root solver.
`timescale 1ns / 1ps
package qr_pkg;

  // Width of a reported root and of the discriminant word
  localparam int OUT_W = 34;
  localparam int DW    = 64;

  // Root count codes
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture coefficients
    logic mul_bb;    // product b*b
    logic mul_ac;    // product a*c, keep b*b
    logic delta;     // form discriminant
    logic sq_init;   // load square root unit
    logic sq_step;   // one root digit
    logic div_init;  // load divider
    logic div_hi;    // numerator -b+s instead of -b-s
    logic div_step;  // one quotient bit
    logic keep_lo;   // save first quotient
    logic fin;       // write result into cache
    logic pub;       // copy cache into output register
    logic from_cache;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic hit;
    logic a_zero;
    logic d_neg;
  } sts_t;

endpackage

[sv/qr_in_if.sv]
// Coefficient channel: valid/ready with coefficients a, b, c.
`timescale 1ns / 1ps
interface qr_in_if #(parameter int COEF_WIDTH = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COEF_WIDTH-1:0] coef_a;
  logic signed [COEF_WIDTH-1:0] coef_b;
  logic signed [COEF_WIDTH-1:0] coef_c;

  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

[sv/qr_out_if.sv]
// Result channel: valid/ready with root count, flags and roots.
`timescale 1ns / 1ps
interface qr_out_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       root_count;
  logic                             degenerate;
  logic signed [qr_pkg::OUT_W-1:0]  root_low;
  logic signed [qr_pkg::OUT_W-1:0]  root_high;
  logic                             from_cache;

  modport source (output valid, root_count, degenerate, root_low, root_high, from_cache,
                  input ready);
  modport sink   (input valid, root_count, degenerate, root_low, root_high, from_cache,
                  output ready);
endinterface

[sv/qr_datapath.sv]
// Datapath: multiplier, digit-serial square root, restoring divider, cache.
`timescale 1ns / 1ps
module qr_datapath #(
  parameter int COEF_WIDTH = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic signed [COEF_WIDTH-1:0]    coef_a,
  input  logic signed [COEF_WIDTH-1:0]    coef_b,
  input  logic signed [COEF_WIDTH-1:0]    coef_c,
  input  qr_pkg::cmd_t                    cmd,
  output qr_pkg::sts_t                    sts,
  output logic [1:0]                      root_count,
  output logic                            degenerate,
  output logic signed [qr_pkg::OUT_W-1:0] root_low,
  output logic signed [qr_pkg::OUT_W-1:0] root_high,
  output logic                            from_cache
);
  localparam int SQW  = 32 + FRAC_BITS;   // root width
  localparam int REMW = SQW + 2;          // square root remainder
  localparam int NUMW = SQW + 2;          // signed numerator / quotient
  localparam int RMW  = COEF_WIDTH + 1;   // divisor magnitude and remainder
  localparam int OW   = qr_pkg::OUT_W;
  localparam int DWW  = qr_pkg::DW;

  logic signed [COEF_WIDTH-1:0]   ca, cb, cc;
  logic [COEF_WIDTH-1:0]          last_a, last_b, last_c;
  logic                           cache_valid;
  logic [1:0]                     cached_count;
  logic                           cached_degenerate;
  logic [OW-1:0]                  cached_low, cached_high;
  logic signed [2*COEF_WIDTH-1:0] prod;
  logic [DWW-1:0]                 bbr, dw, dsh;
  logic [REMW-1:0]                rem;
  logic [SQW-1:0]                 root;
  logic [NUMW-1:0]                qn;
  logic [RMW-1:0]                 rm, dmag;
  logic                           qneg;
  logic signed [NUMW-1:0]         r1;

  // saturate a wide quotient into the root range
  function automatic logic [OW-1:0] clamp(input logic signed [NUMW-1:0] v);
    logic fits;
    fits = (&v[NUMW-1:OW-1]) | ~(|v[NUMW-1:OW-1]);
    if (fits) return v[OW-1:0];
    else if (v[NUMW-1]) return {1'b1, {(OW-1){1'b0}}};
    else return {1'b0, {(OW-1){1'b1}}};
  endfunction

  // status
  assign sts.hit    = cache_valid && (ca == last_a) && (cb == last_b) && (cc == last_c);
  assign sts.a_zero = (ca == '0);
  assign sts.d_neg  = dw[DWW-1];

  // shared multiplier
  logic signed [COEF_WIDTH-1:0] mx, my;
  assign mx = cmd.mul_ac ? ca : cb;
  assign my = cmd.mul_ac ? cc : cb;

  // square root digit step
  logic [REMW-1:0] rem_sh, trial;
  logic            sq_ge;
  assign rem_sh = {rem[REMW-3:0], dsh[DWW-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign sq_ge  = rem_sh >= trial;

  // numerator and divisor setup
  logic signed [NUMW-1:0] base, sx, num;
  logic signed [RMW-1:0]  a2;
  logic [NUMW-1:0]        nabs;
  assign base = -(NUMW'(cb)) <<< FRAC_BITS;
  assign sx   = $signed(NUMW'(root));
  assign num  = cmd.div_hi ? base + sx : base - sx;
  assign nabs = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
  assign a2   = {ca, 1'b0};

  // divider bit step
  logic [RMW:0]           rm_sh;
  logic                   dv_ge;
  logic signed [NUMW-1:0] quot, lo_q, hi_q;
  assign rm_sh = {rm, qn[NUMW-1]};
  assign dv_ge = rm_sh >= {1'b0, dmag};
  assign quot  = qneg ? -$signed(qn) : $signed(qn);
  assign lo_q  = (r1 <= quot) ? r1 : quot;
  assign hi_q  = (r1 <= quot) ? quot : r1;

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ca <= coef_a;
      cb <= coef_b;
      cc <= coef_c;
    end
    if (cmd.mul_bb || cmd.mul_ac) prod <= mx * my;
    if (cmd.mul_ac) bbr <= DWW'($signed(prod));
    if (cmd.delta) dw <= bbr - (DWW'($signed(prod)) << 2);
    if (cmd.sq_init) begin
      dsh  <= dw;
      rem  <= '0;
      root <= '0;
    end else if (cmd.sq_step) begin
      dsh  <= dsh << 2;
      rem  <= sq_ge ? rem_sh - trial : rem_sh;
      root <= {root[SQW-2:0], sq_ge};
    end
    if (cmd.keep_lo) r1 <= quot;
    if (cmd.div_init) begin
      qn   <= nabs;
      rm   <= '0;
      dmag <= ca[COEF_WIDTH-1] ? RMW'(-a2) : RMW'(a2);
      qneg <= num[NUMW-1] ^ ca[COEF_WIDTH-1];
    end else if (cmd.div_step) begin
      rm <= dv_ge ? RMW'(rm_sh - {1'b0, dmag}) : rm_sh[RMW-1:0];
      qn <= {qn[NUMW-2:0], dv_ge};
    end
    if (cmd.pub) begin
      root_count <= cached_count;
      degenerate <= cached_degenerate;
      root_low   <= cached_low;
      root_high  <= cached_high;
      from_cache <= cmd.from_cache;
    end
  end

  // result cache
  always_ff @(posedge clk) begin
    if (rst) begin
      last_a            <= '0;
      last_b            <= '0;
      last_c            <= '0;
      cache_valid       <= 1'b0;
      cached_count      <= qr_pkg::CNT_NONE;
      cached_degenerate <= 1'b0;
      cached_low        <= '0;
      cached_high       <= '0;
    end else if (cmd.fin) begin
      last_a            <= ca;
      last_b            <= cb;
      last_c            <= cc;
      cache_valid       <= 1'b1;
      cached_degenerate <= sts.a_zero;
      if (sts.a_zero || sts.d_neg) begin
        cached_count <= qr_pkg::CNT_NONE;
        cached_low   <= '0;
        cached_high  <= '0;
      end else begin
        cached_count <= (dw == '0) ? qr_pkg::CNT_ONE : qr_pkg::CNT_TWO;
        cached_low   <= clamp(lo_q);
        cached_high  <= clamp(hi_q);
      end
    end
  end
endmodule

[sv/qr_ctrl.sv]
// Controller: sequences multiply, square root, two divisions and publish; a cache hit skips straight to publish.
`timescale 1ns / 1ps
module qr_ctrl #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  qr_pkg::sts_t sts,
  output qr_pkg::cmd_t cmd
);
  localparam int SQW  = 32 + FRAC_BITS;
  localparam int NUMW = SQW + 2;
  localparam int CNTW = $clog2(NUMW + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1;
  localparam logic [3:0] S_MUL1  = 4'd2;
  localparam logic [3:0] S_MUL2  = 4'd3;
  localparam logic [3:0] S_DELTA = 4'd4;
  localparam logic [3:0] S_CLASS = 4'd5;
  localparam logic [3:0] S_SQRT  = 4'd6;
  localparam logic [3:0] S_DIV1I = 4'd7;
  localparam logic [3:0] S_DIV1  = 4'd8;
  localparam logic [3:0] S_DIV2I = 4'd9;
  localparam logic [3:0] S_DIV2  = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;
  localparam logic [3:0] S_PUB   = 4'd12;

  logic [3:0]      state, state_next;
  logic [CNTW-1:0] cnt, cnt_next;
  logic            hit_seen, hit_seen_next;
  logic            can_pub;

  assign in_ready = (state == S_IDLE);
  assign can_pub  = !out_valid || out_ready;

  // next state and commands
  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    hit_seen_next = hit_seen;
    cmd           = '0;
    cmd.from_cache = hit_seen;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        hit_seen_next = sts.hit;
        state_next    = sts.hit ? S_PUB : S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_bb = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_ac = 1'b1;
        state_next = S_DELTA;
      end
      S_DELTA: begin
        cmd.delta  = 1'b1;
        state_next = S_CLASS;
      end
      S_CLASS: begin
        cnt_next = '0;
        if (sts.a_zero || sts.d_neg) begin
          state_next = S_FIN;
        end else begin
          cmd.sq_init = 1'b1;
          state_next  = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sq_step = 1'b1;
        cnt_next    = cnt + 1'b1;
        if (cnt == CNTW'(SQW - 1)) begin
          cnt_next   = '0;
          state_next = S_DIV1I;
        end
      end
      S_DIV1I: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV1;
      end
      S_DIV1: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNTW'(NUMW - 1)) begin
          cnt_next   = '0;
          state_next = S_DIV2I;
        end
      end
      S_DIV2I: begin
        cmd.keep_lo  = 1'b1;
        cmd.div_init = 1'b1;
        cmd.div_hi   = 1'b1;
        state_next   = S_DIV2;
      end
      S_DIV2: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNTW'(NUMW - 1)) begin
          cnt_next   = '0;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_PUB;
      end
      S_PUB: begin
        if (can_pub) begin
          cmd.pub    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and output-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      hit_seen  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      hit_seen <= hit_seen_next;
      if (cmd.pub) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end
endmodule

[sv/quadratic_roots_with_last_result_cache.sv]
// Top level: quadratic real-root solver with a one-entry result cache.
//
//   channel    dir  beat payload
//   coef_in    in   coef_a, coef_b, coef_c (signed, COEF_WIDTH)
//   root_out   out  root_count, degenerate, root_low, root_high, from_cache
//
// A computed beat runs 32+FRAC_BITS square root steps and two 34+FRAC_BITS step
// divisions between accept and output. A cache hit goes from the check straight
// to publish; zero a or a negative discriminant skips the root and the divisions.
// One beat is in work at a time; input is ready again the cycle after publish, and
// the output register lets the next beat in while a result waits.
// Synchronous reset clears control and the cache.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module quadratic_roots_with_last_result_cache #(
  parameter int COEF_WIDTH = 16,
  parameter int FRAC_BITS  = 16
) (
  input logic clk,
  input logic rst,
  qr_in_if.sink    coef_in,
  qr_out_if.source root_out
);
  qr_pkg::cmd_t cmd;
  qr_pkg::sts_t sts;

  qr_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (coef_in.valid),
    .in_ready  (coef_in.ready),
    .out_valid (root_out.valid),
    .out_ready (root_out.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  qr_datapath #(.COEF_WIDTH(COEF_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .coef_a     (coef_in.coef_a),
    .coef_b     (coef_in.coef_b),
    .coef_c     (coef_in.coef_c),
    .cmd        (cmd),
    .sts        (sts),
    .root_count (root_out.root_count),
    .degenerate (root_out.degenerate),
    .root_low   (root_out.root_low),
    .root_high  (root_out.root_high),
    .from_cache (root_out.from_cache)
  );

  // checks
  `ASSERT_NOW(a_pub_no_clobber, cmd.pub, !(root_out.valid && !root_out.ready), "overwrite")
  `ASSERT_NEXT(a_busy_after_accept, coef_in.valid && coef_in.ready, !coef_in.ready, "busy")
  `ASSERT_NOW(a_degenerate_none, root_out.valid && root_out.degenerate, root_out.root_count == qr_pkg::CNT_NONE, "degen")
  `ASSERT_NOW(a_double_equal, root_out.valid && root_out.root_count == qr_pkg::CNT_ONE, root_out.root_low == root_out.root_high, "double")
endmodule
